>>> rtl/tbrl_pkg.sv
// Package for the token bucket rate limiter: sequencer states, register
// indexes, action codes, field widths and the divider request type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tbrl_pkg;

  localparam int RATE_W   = 20;
  localparam int TICK_W   = 32;
  localparam int LIMIT_W  = 52;
  localparam int CREDIT_W = 54;

  localparam logic [1:0] REG_RATE     = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_WINDOW   = 2'd2;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TAKE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CLOAD,
    ST_MUL,
    ST_UPD,
    ST_DIV,
    ST_DIVW,
    ST_WB
  } state_t;

  typedef struct packed {
    logic                    start;
    logic                    neg;
    logic [CREDIT_W-1:0]     mag;
    logic [TICK_W-1:0]       divisor;
  } div_req_t;

endpackage
`default_nettype wire

>>> rtl/tbrl_mul.sv
// Shared 20 x 32 bit multiplier with a registered product.
// Depends on tbrl_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none
module tbrl_mul (
  input  wire                         clk,
  input  wire                         en,
  input  wire [tbrl_pkg::RATE_W-1:0]  a,
  input  wire [tbrl_pkg::TICK_W-1:0]  b,
  output logic [tbrl_pkg::LIMIT_W-1:0] p
);
  import tbrl_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= {{TICK_W{1'b0}}, a} * {{RATE_W{1'b0}}, b};
    end
  end

endmodule
`default_nettype wire

>>> rtl/tbrl_div.sv
// Iterative restoring divider: signed credit by unsigned interval, one
// quotient bit per cycle, quotient truncated toward zero.
// Depends on tbrl_pkg for the request type and widths.
`timescale 1ns / 1ps
`default_nettype none
module tbrl_div (
  input  wire                            clk,
  input  wire                            rst,
  input  wire tbrl_pkg::div_req_t        req,
  output logic                           done,
  output logic [tbrl_pkg::CREDIT_W-1:0]  quo
);
  import tbrl_pkg::*;

  localparam int CNT_W = $clog2(CREDIT_W);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic                neg;
  logic [CREDIT_W-1:0] q;
  logic [TICK_W-1:0]   rem;
  logic [TICK_W-1:0]   dvs;

  logic [TICK_W:0]     rem_sh;
  logic [TICK_W+1:0]   diff;
  logic                qbit;
  logic [TICK_W-1:0]   rem_next;
  logic [CREDIT_W-1:0] q_next;

  always_comb begin
    rem_sh   = {rem, q[CREDIT_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs};
    qbit     = !diff[TICK_W+1];
    rem_next = qbit ? diff[TICK_W-1:0] : rem_sh[TICK_W-1:0];
    q_next   = {q[CREDIT_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CREDIT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.mag;
      rem <= '0;
      dvs <= req.divisor;
      neg <= req.neg;
    end else if (busy) begin
      q   <= q_next;
      rem <= rem_next;
      if (cnt == CNT_W'(CREDIT_W - 1)) begin
        quo <= neg ? (~q_next + 1'b1) : q_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/token_bucket_rate_limiter.sv
// Token bucket rate limiter: one request in, one result out, credit scaled
// by interval ticks. A request runs the multiply, the credit update, the
// divider start, one divider step per quotient bit and the write-back,
// which holds while the output stalls; no new request is taken until the
// result is written back. A config write runs the limit multiply and refill.
// Synchronous active-high reset: rate, window and limit to 0, interval 1, credit empty.
`timescale 1ns / 1ps
`default_nettype none
module token_bucket_rate_limiter (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [55:0] s_tdata,   // elapsed_ticks[31:0], take_count[51:32], zero pad
  input  wire         s_tuser,   // action
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata,   // granted[0], remaining_tokens[54:1], bucket_full[55],
                                 // can_take[56], zero pad
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import tbrl_pkg::*;

  state_t state, state_next;

  logic [RATE_W-1:0]   rate_tokens;
  logic [TICK_W-1:0]   interval_ticks;
  logic [TICK_W-1:0]   window_ticks;
  logic [TICK_W-1:0]   ivl;

  logic                act;
  logic [TICK_W-1:0]   elapsed;
  logic [RATE_W-1:0]   count;

  logic signed [CREDIT_W-1:0] credit;
  logic [LIMIT_W-1:0]  limit_scaled;
  logic                granted;

  logic                mul_en;
  logic [RATE_W-1:0]   mul_a;
  logic [TICK_W-1:0]   mul_b;
  logic [LIMIT_W-1:0]  prod;

  div_req_t            dreq;
  logic                div_done;
  logic [CREDIT_W-1:0] quo;

  logic                cfg_hit;
  logic                in_hit;
  logic                out_free;
  logic signed [CREDIT_W:0] sum;

  assign ivl      = (interval_ticks == '0) ? TICK_W'(1) : interval_ticks;
  assign cfg_hit  = cfg_valid && cfg_ready && (cfg_index <= REG_WINDOW);
  assign in_hit   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign sum      = {credit[CREDIT_W-1], credit} + $signed({3'b000, prod});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cfg_hit) begin
          state_next = ST_CMUL;
        end else if (in_hit) begin
          state_next = ST_MUL;
        end
      end
      ST_CMUL:  state_next = ST_CLOAD;
      ST_CLOAD: state_next = ST_IDLE;
      ST_MUL:   state_next = ST_UPD;
      ST_UPD:   state_next = ST_DIV;
      ST_DIV:   state_next = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cfg_ready    = 1'b0;
    s_tready     = 1'b0;
    mul_en       = 1'b0;
    mul_a        = rate_tokens;
    mul_b        = window_ticks;
    dreq.start   = 1'b0;
    dreq.neg     = credit[CREDIT_W-1];
    dreq.mag     = credit[CREDIT_W-1] ? (~credit + 1'b1) : credit;
    dreq.divisor = ivl;
    case (state)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        s_tready  = !cfg_valid;
      end
      ST_CMUL: mul_en = 1'b1;
      ST_MUL: begin
        mul_en = 1'b1;
        if (act == ACT_TAKE) begin
          mul_a = count;
          mul_b = ivl;
        end else begin
          mul_b = elapsed;
        end
      end
      ST_DIV:  dreq.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers, limit and credit
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_tokens    <= '0;
      interval_ticks <= TICK_W'(1);
      window_ticks   <= '0;
      credit         <= '0;
      limit_scaled   <= '0;
    end else begin
      if (cfg_hit) begin
        case (cfg_index)
          REG_RATE:     rate_tokens    <= cfg_data[RATE_W-1:0];
          REG_INTERVAL: interval_ticks <= cfg_data;
          REG_WINDOW:   window_ticks   <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_CLOAD) begin
        limit_scaled <= prod;
        credit       <= $signed({2'b00, prod});
      end
      if (state == ST_UPD) begin
        if (act == ACT_ADD) begin
          // clamp at the limit
          if (sum > $signed({3'b000, limit_scaled})) begin
            credit <= $signed({2'b00, limit_scaled});
          end else begin
            credit <= sum[CREDIT_W-1:0];
          end
        end else if (!credit[CREDIT_W-1]) begin
          credit <= credit - $signed({2'b00, prod});
        end
      end
    end
  end

  // request capture and grant flag
  always_ff @(posedge clk) begin
    if (in_hit) begin
      act     <= s_tuser;
      elapsed <= s_tdata[31:0];
      count   <= s_tdata[51:32];
    end
    if (state == ST_UPD) begin
      granted <= (act == ACT_TAKE) && !credit[CREDIT_W-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_WB && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WB && out_free) begin
      m_tdata <= {7'b0, !credit[CREDIT_W-1],
                  credit == $signed({2'b00, limit_scaled}), quo, granted};
    end
  end

  tbrl_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  tbrl_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quo  (quo)
  );

endmodule
`default_nettype wire

>>> rtl/tbrl_checker.sv
// Port-level checks for the token bucket rate limiter, bound to the top.
// Depends on tbrl_pkg and token_bucket_rate_limiter.
`timescale 1ns / 1ps
`default_nettype none
module tbrl_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [63:0] m_tdata,
  input wire        cfg_valid,
  input wire        cfg_ready,
  input wire [1:0]  cfg_index
);
  import tbrl_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // one request at a time: busy after acceptance
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !cfg_ready)
    else $error("request accepted while previous still in work");

  // a register write blocks requests while the limit is recomputed
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index <= REG_WINDOW |=> !s_tready)
    else $error("request taken during limit refill");

  // a full bucket is never negative
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[55] |-> m_tdata[56])
    else $error("full bucket flagged with negative credit");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);
`default_nettype wire
